@@ design/rpwa_pkg.sv @@
package rpwa_pkg;

  localparam int unsigned MAX_SAMPLES = 4095;

  localparam int unsigned COUNT_W   = 12;
  localparam int unsigned RAW_W     = 16;
  localparam int unsigned GAIN_W    = 24;
  localparam int unsigned SCALED_W  = 24;
  localparam int unsigned MUL_W     = 25;
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam int unsigned SQ_SUM_W  = 60;
  localparam int unsigned PWR_SUM_W = 61;
  localparam int unsigned QUO_W     = 60;
  localparam int unsigned ROOT_W    = QUO_W / 2;
  localparam int unsigned RMS_W     = 23;
  localparam int unsigned MEAN_W    = 48;

  localparam int unsigned MUL_CNT_W  = $clog2(MUL_W);
  localparam int unsigned DIV_CNT_W  = $clog2(QUO_W);
  localparam int unsigned SQRT_CNT_W = $clog2(ROOT_W);

  localparam logic [1:0] TWO_PHASES = 2'd2;

  typedef enum logic [2:0] {
    CFG_PHASE_COUNT = 3'd0,
    CFG_GAIN_VOLT_A = 3'd1,
    CFG_GAIN_VOLT_B = 3'd2,
    CFG_GAIN_AMP_A  = 3'd3,
    CFG_GAIN_AMP_B  = 3'd4,
    CFG_WINDOW_LIM  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic        [31:0] stamp_seconds;
    logic        [19:0] span_us;
    logic signed [15:0] volt_a_raw;
    logic signed [15:0] volt_b_raw;
    logic signed [15:0] amp_a_raw;
    logic signed [15:0] amp_b_raw;
  } in_t;

  typedef struct packed {
    logic        [31:0] window_start;
    logic        [31:0] window_span_us;
    logic        [11:0] sample_total;
    logic        [22:0] rms_volt_a;
    logic        [22:0] rms_volt_b;
    logic        [22:0] rms_amp_a;
    logic        [22:0] rms_amp_b;
    logic signed [47:0] mean_power_a;
    logic signed [47:0] mean_power_b;
    logic               time_gap;
  } out_t;

endpackage

@@ design/rpwa_mul.sv @@
module rpwa_mul import rpwa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic              done,
  output logic [PROD_W-1:0] product
);

  localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MUL_W - 1);

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  logic [MUL_W-1:0]     areg;
  logic [MUL_W:0]       hi;
  logic [MUL_W-1:0]     lo;
  logic [MUL_W:0]       a_ext;
  logic [MUL_W:0]       addend;
  logic [MUL_W:0]       sum;

  // The last multiplier bit carries negative weight.
  assign a_ext  = {areg[MUL_W-1], areg};
  assign addend = !lo[0] ? '0 : ((cnt == MUL_LAST) ? (~a_ext + 1'b1) : a_ext);
  assign sum    = hi + addend;

  assign product = {hi[MUL_W-1:0], lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        areg <= a;
        hi   <= '0;
        lo   <= b;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        hi <= {sum[MUL_W], sum[MUL_W:1]};
        lo <= {sum[0], lo[MUL_W-1:1]};
        if (cnt == MUL_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

@@ design/rpwa_div.sv @@
module rpwa_div import rpwa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [QUO_W-1:0]   dividend,
  input  logic [COUNT_W-1:0] divisor,
  output logic               done,
  output logic [QUO_W-1:0]   quotient
);

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [COUNT_W-1:0]   dsr;
  logic [COUNT_W-1:0]   rem;
  logic [COUNT_W:0]     trial;
  logic [COUNT_W:0]     diff;
  logic                 ge;

  assign trial = {rem, quotient[QUO_W-1]};
  assign ge    = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dsr      <= divisor;
        rem      <= '0;
        quotient <= dividend;
        cnt      <= '0;
        busy     <= 1'b1;
      end else if (busy) begin
        rem      <= ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
        quotient <= {quotient[QUO_W-2:0], ge};
        if (cnt == DIV_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

@@ design/rpwa_sqrt.sv @@
module rpwa_sqrt import rpwa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [QUO_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam logic [SQRT_CNT_W-1:0] SQRT_LAST = SQRT_CNT_W'(ROOT_W - 1);

  logic                  busy;
  logic [SQRT_CNT_W-1:0] cnt;
  logic [QUO_W-1:0]      rad;
  logic [ROOT_W+1:0]     rem;
  logic [ROOT_W+3:0]     remsh;
  logic [ROOT_W+3:0]     trial;
  logic [ROOT_W+3:0]     diff;
  logic                  ge;

  assign remsh = {rem, rad[QUO_W-1:QUO_W-2]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = remsh >= trial;
  assign diff  = remsh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? diff[ROOT_W+1:0] : remsh[ROOT_W+1:0];
        root <= {root[ROOT_W-2:0], ge};
        rad  <= {rad[QUO_W-3:0], 2'b00};
        if (cnt == SQRT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

@@ design/rms_power_window_accumulator_unit.sv @@
// Windowed true-RMS and active power meter. Each sample transaction is scaled by the
// gain registers and, while its window is open and below the duration and sample
// limits, adds v*v, i*i and v*i per phase. All arithmetic runs through one bit-serial
// multiplier, one bit-serial divider and a two-bits-per-cycle square root. A sample
// that adds to the window takes five multiplies per phase. A sample that neither adds
// nor closes leaves the unit idle. A sample that closes a window waits until the output
// register is free and then takes six divisions and four roots before the result
// transaction appears. The output register holds that result while the next window
// accumulates.
module rms_power_window_accumulator_unit import rpwa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MSTART = 9'b000000010,
    S_MWAIT  = 9'b000000100,
    S_OWAIT  = 9'b000001000,
    S_DSTART = 9'b000010000,
    S_DWAIT  = 9'b000100000,
    S_QSTART = 9'b001000000,
    S_QWAIT  = 9'b010000000,
    S_EMIT   = 9'b100000000
  } state_t;

  typedef enum logic [2:0] {
    K_SCALE_V = 3'd0,
    K_SCALE_I = 3'd1,
    K_SQ_V    = 3'd2,
    K_SQ_I    = 3'd3,
    K_PROD    = 3'd4
  } step_t;

  typedef enum logic [2:0] {
    J_VOLT_A = 3'd0,
    J_VOLT_B = 3'd1,
    J_AMP_A  = 3'd2,
    J_AMP_B  = 3'd3,
    J_PWR_A  = 3'd4,
    J_PWR_B  = 3'd5
  } job_t;

  state_t state;
  step_t  step;
  job_t   job;
  logic   phase;
  logic   two_phase;

  logic [1:0]  phase_count;
  logic [23:0] gain_volt_a;
  logic [23:0] gain_volt_b;
  logic [23:0] gain_amp_a;
  logic [23:0] gain_amp_b;
  logic [31:0] window_limit_us;

  logic [31:0]          open_start;
  logic [31:0]          open_span;
  logic [COUNT_W-1:0]   open_total;
  logic [31:0]          prev_start;
  logic [SQ_SUM_W-1:0]  volt_sq [2];
  logic [SQ_SUM_W-1:0]  amp_sq [2];
  logic [PWR_SUM_W-1:0] pwr_sum [2];

  logic [RAW_W-1:0]    volt_a_raw;
  logic [RAW_W-1:0]    volt_b_raw;
  logic [RAW_W-1:0]    amp_a_raw;
  logic [RAW_W-1:0]    amp_b_raw;
  logic [SCALED_W-1:0] volt_scaled;
  logic [SCALED_W-1:0] amp_scaled;

  logic               accept;
  logic               restart;
  logic [31:0]        base_span;
  logic [32:0]        span_sum;
  logic [31:0]        new_span;
  logic [31:0]        eff_start;
  logic [COUNT_W-1:0] eff_total;
  logic               do_acc;
  logic               do_close;

  logic [RAW_W-1:0]    raw_v;
  logic [RAW_W-1:0]    raw_i;
  logic [GAIN_W-1:0]   gain_v;
  logic [GAIN_W-1:0]   gain_i;
  logic [MUL_W-1:0]    mul_a;
  logic [MUL_W-1:0]    mul_b;
  logic                mul_done;
  logic [PROD_W-1:0]   mul_prod;

  logic [PWR_SUM_W-1:0] pwr_sel;
  logic [PWR_SUM_W-1:0] pwr_mag;
  logic [QUO_W-1:0]     dividend;
  logic                 div_done;
  logic [QUO_W-1:0]     quotient;
  logic [QUO_W-1:0]     mean_full;
  logic                 sqrt_done;
  logic [ROOT_W-1:0]    root;
  logic [RMS_W-1:0]     rms_sat;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign restart   = (in_data.stamp_seconds < open_start) || (open_total == '0);
  assign base_span = restart ? '0 : open_span;
  assign span_sum  = {1'b0, base_span} + {13'b0, in_data.span_us};
  assign new_span  = span_sum[32] ? '1 : span_sum[31:0];
  assign eff_start = restart ? in_data.stamp_seconds : open_start;
  assign eff_total = restart ? '0 : open_total;
  assign do_acc    = (new_span < window_limit_us) && (in_data.stamp_seconds == eff_start) &&
                     (eff_total < COUNT_W'(MAX_SAMPLES));
  assign do_close  = (in_data.stamp_seconds != eff_start);

  assign raw_v  = phase ? volt_b_raw : volt_a_raw;
  assign raw_i  = phase ? amp_b_raw : amp_a_raw;
  assign gain_v = phase ? gain_volt_b : gain_volt_a;
  assign gain_i = phase ? gain_amp_b : gain_amp_a;

  always_comb begin
    case (step)
      K_SCALE_V: begin
        mul_a = {{(MUL_W-RAW_W){raw_v[RAW_W-1]}}, raw_v};
        mul_b = {1'b0, gain_v};
      end
      K_SCALE_I: begin
        mul_a = {{(MUL_W-RAW_W){raw_i[RAW_W-1]}}, raw_i};
        mul_b = {1'b0, gain_i};
      end
      K_SQ_V: begin
        mul_a = {volt_scaled[SCALED_W-1], volt_scaled};
        mul_b = {volt_scaled[SCALED_W-1], volt_scaled};
      end
      K_SQ_I: begin
        mul_a = {amp_scaled[SCALED_W-1], amp_scaled};
        mul_b = {amp_scaled[SCALED_W-1], amp_scaled};
      end
      K_PROD: begin
        mul_a = {volt_scaled[SCALED_W-1], volt_scaled};
        mul_b = {amp_scaled[SCALED_W-1], amp_scaled};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign pwr_sel = (job == J_PWR_B) ? pwr_sum[1] : pwr_sum[0];
  assign pwr_mag = pwr_sel[PWR_SUM_W-1] ? (~pwr_sel + 1'b1) : pwr_sel;

  always_comb begin
    case (job)
      J_VOLT_A: dividend = volt_sq[0];
      J_VOLT_B: dividend = volt_sq[1];
      J_AMP_A:  dividend = amp_sq[0];
      J_AMP_B:  dividend = amp_sq[1];
      default:  dividend = pwr_mag[QUO_W-1:0];
    endcase
  end

  assign mean_full = pwr_sel[PWR_SUM_W-1] ? (~quotient + 1'b1) : quotient;
  assign rms_sat   = (|root[ROOT_W-1:RMS_W]) ? '1 : root[RMS_W-1:0];

  rpwa_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (state == S_MSTART),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  rpwa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DSTART),
    .dividend (dividend),
    .divisor  (open_total),
    .done     (div_done),
    .quotient (quotient)
  );

  rpwa_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_QSTART),
    .radicand (quotient),
    .done     (sqrt_done),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      step            <= K_SCALE_V;
      job             <= J_VOLT_A;
      phase           <= 1'b0;
      two_phase       <= 1'b0;
      phase_count     <= 2'd1;
      gain_volt_a     <= 24'd65536;
      gain_volt_b     <= 24'd65536;
      gain_amp_a      <= 24'd65536;
      gain_amp_b      <= 24'd65536;
      window_limit_us <= 32'd1002000;
      open_start      <= '0;
      open_span       <= '0;
      open_total      <= '0;
      prev_start      <= '0;
      volt_sq[0]      <= '0;
      volt_sq[1]      <= '0;
      amp_sq[0]       <= '0;
      amp_sq[1]       <= '0;
      pwr_sum[0]      <= '0;
      pwr_sum[1]      <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_PHASE_COUNT: phase_count     <= cfg_data[1:0];
          CFG_GAIN_VOLT_A: gain_volt_a     <= cfg_data[23:0];
          CFG_GAIN_VOLT_B: gain_volt_b     <= cfg_data[23:0];
          CFG_GAIN_AMP_A:  gain_amp_a      <= cfg_data[23:0];
          CFG_GAIN_AMP_B:  gain_amp_b      <= cfg_data[23:0];
          CFG_WINDOW_LIM:  window_limit_us <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            volt_a_raw <= in_data.volt_a_raw;
            volt_b_raw <= in_data.volt_b_raw;
            amp_a_raw  <= in_data.amp_a_raw;
            amp_b_raw  <= in_data.amp_b_raw;
            open_start <= eff_start;
            open_span  <= new_span;
            open_total <= eff_total;
            two_phase  <= (phase_count == TWO_PHASES);
            phase      <= 1'b0;
            step       <= K_SCALE_V;
            if (restart) begin
              volt_sq[0] <= '0;
              volt_sq[1] <= '0;
              amp_sq[0]  <= '0;
              amp_sq[1]  <= '0;
              pwr_sum[0] <= '0;
              pwr_sum[1] <= '0;
            end
            if (do_acc) begin
              state <= S_MSTART;
            end else if (do_close) begin
              state <= S_OWAIT;
            end
          end
        end
        S_MSTART: begin
          state <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mul_done) begin
            state <= S_MSTART;
            case (step)
              K_SCALE_V: begin
                volt_scaled <= mul_prod[SCALED_W+15:16];
                step        <= K_SCALE_I;
              end
              K_SCALE_I: begin
                amp_scaled <= mul_prod[SCALED_W+15:16];
                step       <= K_SQ_V;
              end
              K_SQ_V: begin
                volt_sq[phase] <= volt_sq[phase] + {12'b0, mul_prod[47:0]};
                step           <= K_SQ_I;
              end
              K_SQ_I: begin
                amp_sq[phase] <= amp_sq[phase] + {12'b0, mul_prod[47:0]};
                step          <= K_PROD;
              end
              default: begin
                pwr_sum[phase] <= pwr_sum[phase] +
                                  {{(PWR_SUM_W-PROD_W){mul_prod[PROD_W-1]}}, mul_prod};
                step           <= K_SCALE_V;
                if (!phase && two_phase) begin
                  phase <= 1'b1;
                end else begin
                  open_total <= open_total + 1'b1;
                  state      <= S_IDLE;
                end
              end
            endcase
          end
        end
        S_OWAIT: begin
          if (!out_valid) begin
            job   <= J_VOLT_A;
            state <= S_DSTART;
          end
        end
        S_DSTART: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            case (job)
              J_PWR_A: begin
                out_data.mean_power_a <= mean_full[MEAN_W-1:0];
                job                   <= J_PWR_B;
                state                 <= S_DSTART;
              end
              J_PWR_B: begin
                out_data.mean_power_b <= mean_full[MEAN_W-1:0];
                state                 <= S_EMIT;
              end
              default: begin
                state <= S_QSTART;
              end
            endcase
          end
        end
        S_QSTART: begin
          state <= S_QWAIT;
        end
        S_QWAIT: begin
          if (sqrt_done) begin
            state <= S_DSTART;
            case (job)
              J_VOLT_A: begin
                out_data.rms_volt_a <= rms_sat;
                job                 <= J_VOLT_B;
              end
              J_VOLT_B: begin
                out_data.rms_volt_b <= rms_sat;
                job                 <= J_AMP_A;
              end
              J_AMP_A: begin
                out_data.rms_amp_a <= rms_sat;
                job                <= J_AMP_B;
              end
              default: begin
                out_data.rms_amp_b <= rms_sat;
                job                <= J_PWR_A;
              end
            endcase
          end
        end
        S_EMIT: begin
          out_data.window_start   <= open_start;
          out_data.window_span_us <= open_span;
          out_data.sample_total   <= open_total;
          out_data.time_gap       <= (prev_start != '0) && ((open_start - prev_start) > 32'd1);
          out_valid               <= 1'b1;
          prev_start              <= open_start;
          open_total              <= '0;
          state                   <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/rpwa_checker.sv @@
module rpwa_checker import rpwa_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input in_t         in_data,
  input logic        out_valid,
  input logic        out_stall,
  input out_t        out_data,
  input logic        cfg_write,
  input logic [2:0]  cfg_index,
  input logic [31:0] cfg_data
);

  // A stalled result transaction stays offered.
  assert property (@(posedge clk) disable iff (rst) out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // Every emitted window counted at least one sample.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> out_data.sample_total != '0)
    else $error("result with empty window");

  // A new result appears only at the end of work during which input was stalled.
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a closing sample in progress");

endmodule

bind rms_power_window_accumulator_unit rpwa_checker u_rpwa_checker (.*);
